// ===== src/cra_pkg.sv =====
package cra_pkg;

  // Field and register widths
  localparam int CH_W     = 8;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 25;
  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 13;
  localparam int POS_W    = SIZE_W + 1;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = COORD_W;

  // Clipping arithmetic: wide enough for coordinate plus size sums
  localparam int CLIP_W     = 20;
  localparam int ALIGN_BITS = 2;
  localparam int ALIGN      = 1 << ALIGN_BITS;

  // Mean division: quotient never exceeds one channel's range
  localparam int QUOT_BITS = CH_W;
  localparam int DIV_W     = SUM_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CH_W-1:0]    CH_MASK   = 8'hff;
  localparam logic [CH_W-1:0]    CH_ZERO   = 8'h00;

  // Divider lanes
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;
  localparam int LANES      = 3;

  // Parameter defaults
  localparam int MAX_LINE_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;

  // Register reset values
  localparam logic [SIZE_W-1:0] SCREEN_W_RST = 13'd1920;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST = 13'd1080;

  typedef enum logic [CFG_AW-1:0] {
    CFG_REGION_X     = 4'd0,
    CFG_REGION_Y     = 4'd1,
    CFG_REGION_W     = 4'd2,
    CFG_REGION_H     = 4'd3,
    CFG_MONITOR_LEFT = 4'd4,
    CFG_MONITOR_TOP  = 4'd5,
    CFG_SCREEN_W     = 4'd6,
    CFG_SCREEN_H     = 4'd7
  } cfg_idx_e;

  // Clipped rectangle in frame coordinates, plus the line length
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] x_lo;
    logic [SIZE_W-1:0] x_hi;
    logic [SIZE_W-1:0] y_lo;
    logic [SIZE_W-1:0] y_hi;
    logic [POS_W-1:0]  line_len;
  } region_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
  } cmd_t;

endpackage

// ===== src/clipped_region_average_rgb_unit.sv =====
// Channel   Direction  Handshake              Payload
// config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
// pixel     in         in_valid_i/in_ready_o  blue_i, green_i, red_i, end_of_frame_i
// average   out        out_valid_o/out_ready_i avg_red_o, avg_green_o, avg_blue_o,
//                                             outside_o, pixel_count_o
//
// Pixels are taken one per cycle while in_ready_o is high. The end-of-frame
// pixel starts a restoring division (one quotient bit per cycle, three lanes),
// then the result register is loaded: in_ready_o is low after it through the
// division and the load, more while a previous result waits on out_ready_i.
// Reset sets the registers to their defaults and clears position and sums.
module clipped_region_average_rgb_unit
  import cra_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CH_W-1:0]    blue_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    red_i,
  input  logic               end_of_frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    avg_red_o,
  output logic [CH_W-1:0]    avg_green_o,
  output logic [CH_W-1:0]    avg_blue_o,
  output logic               outside_o,
  output logic [COUNT_W-1:0] pixel_count_o
);

  region_t region;
  cmd_t    cmd;

  cra_region #(
    .MAX_LINE (MAX_LINE)
  ) u_region (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .region_o    (region)
  );

  cra_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .end_of_frame_i (end_of_frame_i),
    .out_ready_i    (out_ready_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .cmd_o          (cmd)
  );

  cra_datapath #(
    .MAX_LINE (MAX_LINE),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .region_i      (region),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .avg_red_o     (avg_red_o),
    .avg_green_o   (avg_green_o),
    .avg_blue_o    (avg_blue_o),
    .outside_o     (outside_o),
    .pixel_count_o (pixel_count_o)
  );

`ifndef SYNTHESIS
  // Hold off pixels while the frame's averages are computed
  a_busy_after_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_frame_i |=> !in_ready_o)
    else $error("pixel accepted during end-of-frame division");

  // An off-monitor result is black with no pixels
  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outside_o |-> (avg_red_o == CH_ZERO && avg_green_o == CH_ZERO &&
                                  avg_blue_o == CH_ZERO && pixel_count_o == '0))
    else $error("outside result carries nonzero data");

  // No pixels summed gives zero averages
  a_empty_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_count_o == '0 |-> (avg_red_o == CH_ZERO &&
                                            avg_green_o == CH_ZERO &&
                                            avg_blue_o == CH_ZERO))
    else $error("empty region result has nonzero average");

  // The controller never hands out two of accept, div_step and load_out at once
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.div_step, cmd.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== src/cra_region.sv =====
module cra_region
  import cra_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output region_t           region_o
);

  logic signed [COORD_W-1:0] region_x_q, region_y_q, monitor_left_q, monitor_top_q;
  logic [SIZE_W-1:0]         region_w_q, region_h_q, screen_width_q, screen_height_q;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_x_q      <= '0;
      region_y_q      <= '0;
      region_w_q      <= '0;
      region_h_q      <= '0;
      monitor_left_q  <= '0;
      monitor_top_q   <= '0;
      screen_width_q  <= SCREEN_W_RST;
      screen_height_q <= SCREEN_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_REGION_X:     region_x_q      <= cfg_wdata_i;
        CFG_REGION_Y:     region_y_q      <= cfg_wdata_i;
        CFG_REGION_W:     region_w_q      <= cfg_wdata_i[SIZE_W-1:0];
        CFG_REGION_H:     region_h_q      <= cfg_wdata_i[SIZE_W-1:0];
        CFG_MONITOR_LEFT: monitor_left_q  <= cfg_wdata_i;
        CFG_MONITOR_TOP:  monitor_top_q   <= cfg_wdata_i;
        CFG_SCREEN_W:     screen_width_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SCREEN_H:     screen_height_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CLIP_W-1:0] x, y, w, h, left, top, sw, sh;
  logic signed [CLIP_W-1:0] xr, yr, xa, ya, wa, ha, wb, hb, wf;
  logic signed [CLIP_W-1:0] x_end, y_end;
  logic                     off_screen;

  // Clip the rectangle to the monitor and align its width down
  always_comb begin
    x    = CLIP_W'(region_x_q);
    y    = CLIP_W'(region_y_q);
    left = CLIP_W'(monitor_left_q);
    top  = CLIP_W'(monitor_top_q);
    w    = signed'(CLIP_W'(region_w_q));
    h    = signed'(CLIP_W'(region_h_q));
    sw   = signed'(CLIP_W'(screen_width_q));
    sh   = signed'(CLIP_W'(screen_height_q));

    off_screen = (x + w < left) || (x > left + sw) || (y + h < top) || (y > top + sh);

    xr = x - left;
    yr = y - top;
    if (xr < 0) begin
      wa = w + xr;
      xa = '0;
    end else begin
      wa = w;
      xa = xr;
    end
    if (yr < 0) begin
      ha = h + yr;
      ya = '0;
    end else begin
      ha = h;
      ya = yr;
    end
    wb = (xa + wa > sw) ? sw - xa : wa;
    hb = (ya + ha > sh) ? sh - ya : ha;
    wf = (wb >>> ALIGN_BITS) <<< ALIGN_BITS;

    x_end = xa + wf;
    y_end = ya + hb;

    region_o.valid = !off_screen && (wb >= ALIGN) && (hb > 0);
    region_o.x_lo  = xa[SIZE_W-1:0];
    region_o.x_hi  = x_end[SIZE_W-1:0];
    region_o.y_lo  = ya[SIZE_W-1:0];
    region_o.y_hi  = y_end[SIZE_W-1:0];

    // Line length: screen width capped at the line buffer, never zero
    if (POS_W'(screen_width_q) > POS_W'(MAX_LINE)) begin
      region_o.line_len = POS_W'(MAX_LINE);
    end else if (screen_width_q == '0) begin
      region_o.line_len = POS_W'(1);
    end else begin
      region_o.line_len = POS_W'(screen_width_q);
    end
  end

endmodule

// ===== src/cra_ctrl.sv =====
module cra_ctrl
  import cra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic end_of_frame_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_HOLD
  } state_e;

  localparam int STEP_W = $clog2(QUOT_BITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_BITS - 1);

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;

  // Issue datapath commands
  always_comb begin
    cmd_o.accept    = (state_q == ST_ACCUM) && in_valid_i;
    cmd_o.start_div = cmd_o.accept && end_of_frame_i;
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.load_out  = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == ST_ACCUM);
  assign out_valid_o = out_valid_q;

  // Sequence accumulate, divide and hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_ACCUM: begin
          if (cmd_o.start_div) begin
            state_q <= ST_DIVIDE;
            step_q  <= '0;
          end
        end
        ST_DIVIDE: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (cmd_o.load_out) begin
            state_q <= ST_ACCUM;
          end
        end
        default: state_q <= ST_ACCUM;
      endcase

      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/cra_datapath.sv =====
module cra_datapath
  import cra_pkg::*;
#(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  region_t            region_i,
  input  logic [CH_W-1:0]    blue_i,
  input  logic [CH_W-1:0]    green_i,
  input  logic [CH_W-1:0]    red_i,
  output logic [CH_W-1:0]    avg_red_o,
  output logic [CH_W-1:0]    avg_green_o,
  output logic [CH_W-1:0]    avg_blue_o,
  output logic               outside_o,
  output logic [COUNT_W-1:0] pixel_count_o
);

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [COL_W-1:0]   column_q;
  logic [ROW_W-1:0]   row_q;
  logic [SUM_W-1:0]   sum_q [LANES];
  logic [COUNT_W-1:0] count_q;

  logic [CH_W-1:0]    pix [LANES];
  logic [SUM_W-1:0]   sum_d [LANES];
  logic [COUNT_W-1:0] count_d;
  logic [SUM_W:0]     sum_wide [LANES];
  logic               hit;
  logic [POS_W-1:0]   col_inc;
  logic [ROW_W:0]     row_inc;

  assign pix[LANE_RED]   = red_i;
  assign pix[LANE_GREEN] = green_i;
  assign pix[LANE_BLUE]  = blue_i;

  // Test the current pixel against the clipped rectangle
  assign hit = region_i.valid
            && (POS_W'(column_q) >= POS_W'(region_i.x_lo))
            && (POS_W'(column_q) <  POS_W'(region_i.x_hi))
            && (POS_W'(row_q)    >= POS_W'(region_i.y_lo))
            && (POS_W'(row_q)    <  POS_W'(region_i.y_hi));

  // Saturating sums and count including this pixel
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_wide[l] = {1'b0, sum_q[l]} + (SUM_W + 1)'(pix[l]);
      if (!hit) begin
        sum_d[l] = sum_q[l];
      end else if (sum_wide[l][SUM_W]) begin
        sum_d[l] = SUM_MAX;
      end else begin
        sum_d[l] = sum_wide[l][SUM_W-1:0];
      end
    end
    count_d = (hit && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
  end

  assign col_inc = POS_W'(column_q) + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;

  // Advance raster position and accumulators; clear at end of frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      count_q  <= '0;
      for (int l = 0; l < LANES; l++) begin
        sum_q[l] <= '0;
      end
    end else if (cmd_i.accept) begin
      if (cmd_i.start_div) begin
        column_q <= '0;
        row_q    <= '0;
        count_q  <= '0;
        for (int l = 0; l < LANES; l++) begin
          sum_q[l] <= '0;
        end
      end else begin
        count_q <= count_d;
        for (int l = 0; l < LANES; l++) begin
          sum_q[l] <= sum_d[l];
        end
        if (col_inc >= region_i.line_len) begin
          column_q <= '0;
          row_q    <= (row_inc >= (ROW_W + 1)'(MAX_ROWS)) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          column_q <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  // Restoring divider, one quotient bit per step on all lanes
  logic [DIV_W-1:0]     rem_q [LANES];
  logic [QUOT_BITS-1:0] quot_q [LANES];
  logic [DIV_W-1:0]     dsh_q;
  logic [COUNT_W-1:0]   cnt_hold_q;
  logic                 outside_hold_q;
  logic                 empty_hold_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l]  <= (DIV_W'(sum_d[l]) << 1) + DIV_W'(count_d);
        quot_q[l] <= '0;
      end
      dsh_q          <= DIV_W'(count_d) << (QUOT_BITS);
      cnt_hold_q     <= count_d;
      outside_hold_q <= !region_i.valid;
      empty_hold_q   <= (count_d == '0);
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_q[l] >= dsh_q) begin
          rem_q[l]  <= rem_q[l] - dsh_q;
          quot_q[l] <= {quot_q[l][QUOT_BITS-2:0], 1'b1};
        end else begin
          quot_q[l] <= {quot_q[l][QUOT_BITS-2:0], 1'b0};
        end
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (outside_hold_q || empty_hold_q) begin
        avg_red_o     <= CH_ZERO;
        avg_green_o   <= CH_ZERO;
        avg_blue_o    <= CH_ZERO;
        pixel_count_o <= outside_hold_q ? '0 : cnt_hold_q;
      end else begin
        avg_red_o     <= quot_q[LANE_RED]   & CH_MASK;
        avg_green_o   <= quot_q[LANE_GREEN] & CH_MASK;
        avg_blue_o    <= quot_q[LANE_BLUE]  & CH_MASK;
        pixel_count_o <= cnt_hold_q;
      end
      outside_o <= outside_hold_q;
    end
  end

endmodule
